/* rtl/core/pbpm_pkg.sv */
package pbpm_pkg;

    // Pool size and derived widths.
    localparam int DEPTH     = 64;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int HANDLE_W  = 6;
    localparam int LEVEL_W   = 7;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;
    localparam int NUM_RINGS = 3;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [ACT_W-1:0] {
        ACT_FREE_RET   = 3'd0,
        ACT_FREE_TAKE  = 3'd1,
        ACT_AUDIO_PUT  = 3'd2,
        ACT_AUDIO_TAKE = 3'd3,
        ACT_VIDEO_PUT  = 3'd4,
        ACT_VIDEO_TAKE = 3'd5,
        ACT_FLUSH      = 3'd6,
        ACT_NOP        = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        RING_FREE  = 2'd0,
        RING_AUDIO = 2'd1,
        RING_VIDEO = 2'd2
    } ring_id_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Memory requests from the sequencer: one write and one read per cycle,
    // steered to a ring by the one-hot enables.
    typedef struct packed {
        logic [NUM_RINGS-1:0] we;
        logic [NUM_RINGS-1:0] re;
        logic [PTR_W-1:0]     waddr;
        logic [PTR_W-1:0]     raddr;
        logic [HANDLE_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                valid;
        status_t             status;
        logic [LEVEL_W-1:0]  free_level;
        logic [LEVEL_W-1:0]  audio_level;
        logic [LEVEL_W-1:0]  video_level;
    } result_t;

    // Ring pointer advance with wrap at DEPTH.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_LAST) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

/* rtl/core/pbpm_ram.sv */
module pbpm_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 6
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
    input  logic [WIDTH_P-1:0]                         wdata,
    input  logic                                       re,
    input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
    output logic [WIDTH_P-1:0]                         rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pbpm_free_ram.sv */
module pbpm_free_ram
    import pbpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                we,
    input  logic [PTR_W-1:0]    waddr,
    input  logic [HANDLE_W-1:0] wdata,
    input  logic                re,
    input  logic [PTR_W-1:0]    raddr,
    output logic [HANDLE_W-1:0] rdata
);

    // An entry never written since reset reads as its own index.
    logic [HANDLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    written_reg;
    logic [HANDLE_W-1:0] rd_mem_reg;
    logic                rd_written_reg;
    logic [PTR_W-1:0]    rd_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (we)
        begin
            written_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_mem_reg     <= mem[raddr];
            rd_written_reg <= written_reg[raddr];
            rd_addr_reg    <= raddr;
        end
    end

    assign rdata = rd_written_reg ? rd_mem_reg : HANDLE_W'(rd_addr_reg);

endmodule

/* rtl/core/pbpm_ctrl.sv */
module pbpm_ctrl
    import pbpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  action_t             start_action,
    input  logic [HANDLE_W-1:0] start_handle,
    output logic                idle,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res,
    output mem_req_t            req,
    input  logic [HANDLE_W-1:0] free_rdata,
    input  logic [HANDLE_W-1:0] audio_rdata,
    input  logic [HANDLE_W-1:0] video_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_DRAIN_RD,
        S_DRAIN_WR,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    action_t             act_reg, act_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    ring_id_t            sel_reg, sel_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;
    logic                valid_reg, valid_next;
    status_t             status_reg, status_next;
    logic                lost_reg, lost_next;

    logic [PTR_W-1:0] head_reg [NUM_RINGS];
    logic [PTR_W-1:0] head_next [NUM_RINGS];
    logic [PTR_W-1:0] tail_reg [NUM_RINGS];
    logic [PTR_W-1:0] tail_next [NUM_RINGS];
    logic [CNT_W-1:0] cnt_reg [NUM_RINGS];
    logic [CNT_W-1:0] cnt_next [NUM_RINGS];

    // Shared ring update unit: one ring, one put or take, per cycle.
    ring_id_t         op_sel;
    logic             op_take;
    logic [CNT_W-1:0] alu_cnt;
    logic [PTR_W-1:0] alu_ptr;
    logic [PTR_W-1:0] alu_ptr_nxt;
    logic [CNT_W-1:0] alu_cnt_nxt;
    logic             alu_ok;
    logic             alu_commit;
    logic             act_is_take;
    logic [HANDLE_W-1:0] rdata_sel;

    always_comb
    begin
        case (act_reg) inside
            ACT_FREE_TAKE, ACT_AUDIO_TAKE, ACT_VIDEO_TAKE: act_is_take = 1'b1;
            default:                                       act_is_take = 1'b0;
        endcase
    end

    always_comb
    begin
        op_sel  = (state_reg == S_DRAIN_WR) ? RING_FREE : sel_reg;
        op_take = (state_reg == S_DRAIN_WR) ? 1'b0
                : (state_reg == S_EXEC)     ? act_is_take
                :                             1'b1;
    end

    always_comb
    begin
        alu_cnt     = cnt_reg[op_sel];
        alu_ptr     = op_take ? head_reg[op_sel] : tail_reg[op_sel];
        alu_ptr_nxt = ptr_inc(alu_ptr);
        alu_cnt_nxt = op_take ? (alu_cnt - CNT_W'(1)) : (alu_cnt + CNT_W'(1));
        alu_ok      = op_take ? (alu_cnt != '0) : (alu_cnt < CNT_FULL);
    end

    always_comb
    begin
        unique case (sel_reg)
            RING_AUDIO: rdata_sel = audio_rdata;
            RING_VIDEO: rdata_sel = video_rdata;
            default:    rdata_sel = free_rdata;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        handle_next = handle_reg;
        sel_next    = sel_reg;
        hout_next   = hout_reg;
        valid_next  = valid_reg;
        status_next = status_reg;
        lost_next   = lost_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        req         = '0;
        alu_commit  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next    = start_action;
                    handle_next = start_handle;
                    hout_next   = '0;
                    valid_next  = 1'b0;
                    status_next = ST_OK;
                    lost_next   = 1'b0;
                    unique case (start_action)
                        ACT_NOP:
                        begin
                            state_next = S_DONE;
                        end
                        ACT_FLUSH:
                        begin
                            sel_next   = RING_AUDIO;
                            state_next = S_DRAIN_RD;
                        end
                        ACT_FREE_RET, ACT_FREE_TAKE:
                        begin
                            sel_next   = RING_FREE;
                            state_next = S_EXEC;
                        end
                        ACT_AUDIO_PUT, ACT_AUDIO_TAKE:
                        begin
                            sel_next   = RING_AUDIO;
                            state_next = S_EXEC;
                        end
                        default:
                        begin
                            sel_next   = RING_VIDEO;
                            state_next = S_EXEC;
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                if (alu_ok)
                begin
                    alu_commit = 1'b1;
                    if (op_take)
                    begin
                        req.re[op_sel] = 1'b1;
                        req.raddr      = alu_ptr;
                        state_next     = S_RDWAIT;
                    end
                    else
                    begin
                        req.we[op_sel] = 1'b1;
                        req.waddr      = alu_ptr;
                        req.wdata      = handle_reg;
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    status_next = op_take ? ST_EMPTY : ST_FULL;
                    state_next  = S_DONE;
                end
            end

            S_RDWAIT:
            begin
                hout_next  = rdata_sel;
                valid_next = 1'b1;
                state_next = S_DONE;
            end

            S_DRAIN_RD:
            begin
                if (alu_ok)
                begin
                    alu_commit     = 1'b1;
                    req.re[op_sel] = 1'b1;
                    req.raddr      = alu_ptr;
                    state_next     = S_DRAIN_WR;
                end
                else
                begin
                    head_next[sel_reg] = '0;
                    tail_next[sel_reg] = '0;
                    if (sel_reg == RING_AUDIO)
                    begin
                        sel_next = RING_VIDEO;
                    end
                    else
                    begin
                        status_next = lost_reg ? ST_FULL : ST_OK;
                        state_next  = S_DONE;
                    end
                end
            end

            S_DRAIN_WR:
            begin
                if (alu_ok)
                begin
                    alu_commit        = 1'b1;
                    req.we[RING_FREE] = 1'b1;
                    req.waddr         = alu_ptr;
                    req.wdata         = rdata_sel;
                end
                else
                begin
                    lost_next = 1'b1;
                end
                state_next = S_DRAIN_RD;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (alu_commit)
        begin
            if (op_take)
            begin
                head_next[op_sel] = alu_ptr_nxt;
            end
            else
            begin
                tail_next[op_sel] = alu_ptr_nxt;
            end
            cnt_next[op_sel] = alu_cnt_nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= ACT_NOP;
            handle_reg <= '0;
            sel_reg    <= RING_FREE;
            hout_reg   <= '0;
            valid_reg  <= 1'b0;
            status_reg <= ST_OK;
            lost_reg   <= 1'b0;
            for (int i = 0; i < NUM_RINGS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            cnt_reg[RING_FREE] <= CNT_FULL;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            handle_reg <= handle_next;
            sel_reg    <= sel_next;
            hout_reg   <= hout_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
            lost_reg   <= lost_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.handle      = hout_reg;
        res.valid       = valid_reg;
        res.status      = status_reg;
        res.free_level  = LEVEL_W'(cnt_reg[RING_FREE]);
        res.audio_level = LEVEL_W'(cnt_reg[RING_AUDIO]);
        res.video_level = LEVEL_W'(cnt_reg[RING_VIDEO]);
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[RING_FREE] <= CNT_FULL) && (cnt_reg[RING_AUDIO] <= CNT_FULL)
        && (cnt_reg[RING_VIDEO] <= CNT_FULL))
        else $error("ring count above pool size");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(req.we) && $onehot0(req.re))
        else $error("more than one ring accessed on a port");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && act_reg == ACT_FLUSH) |->
        (cnt_reg[RING_AUDIO] == '0 && cnt_reg[RING_VIDEO] == '0
         && head_reg[RING_AUDIO] == '0 && tail_reg[RING_VIDEO] == '0))
        else $error("class ring not empty after flush");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && valid_reg) |-> (status_reg == ST_OK))
        else $error("taken handle reported with error status");

    a_free_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[RING_FREE] == '0 || cnt_reg[RING_FREE] == CNT_FULL) |->
        (head_reg[RING_FREE] == tail_reg[RING_FREE]))
        else $error("free ring pointers disagree with its count");
`endif

endmodule

/* rtl/core/packet_buffer_pool_manager_unit.sv */
// Packet buffer pool manager. The block keeps a pool of DEPTH buffer handles
// in three rings: a free ring that holds every handle in order after reset,
// and an audio and a video ring that start out empty. Each transfer on the
// input stream carries one request, selected by s_axis_tuser: return a handle
// to the free ring, take one from it, put to or take from the audio or video
// ring, or flush, which moves every queued audio handle and then every video
// handle, oldest first, onto the tail of the free ring. Every request makes
// exactly one transfer on the output stream with the taken handle (if any),
// a status code and the three ring levels after the request. The block works
// on one request at a time: a single ring update unit advances one pointer and
// one count per cycle, and the ring memories have registered reads. A take
// that succeeds waits for the memory read before its result is ready, and a
// flush reads each queued handle and then writes it to the free ring; a handle
// that finds the free ring full is dropped and the status reports it. A
// finished result waits in the output register, so the next request
// is accepted while the previous result has not yet been taken. No clearing
// pass runs after reset; the block is ready at once.
module packet_buffer_pool_manager_unit
    import pbpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] handle, [7:6] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] action

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] out_handle, [7:6] status,
                                        // [14:8] free_level, [21:15] audio_level,
                                        // [28:22] video_level, [31:29] zero
    output logic        m_axis_tuser    // [0] out_valid
);

    logic                in_xfer;
    logic                ctrl_idle;
    logic                res_valid;
    logic                res_ready;
    result_t             res;
    mem_req_t            req;
    logic [HANDLE_W-1:0] free_rdata;
    logic [HANDLE_W-1:0] audio_rdata;
    logic [HANDLE_W-1:0] video_rdata;

    logic                out_tvalid_reg, out_tvalid_next;
    logic [31:0]         out_tdata_reg, out_tdata_next;
    logic                out_tuser_reg, out_tuser_next;

    // A request is taken whenever the sequencer has nothing in flight.
    assign s_axis_tready = ctrl_idle;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    pbpm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_xfer),
        .start_action (action_t'(s_axis_tuser)),
        .start_handle (s_axis_tdata[HANDLE_W-1:0]),
        .idle         (ctrl_idle),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .req          (req),
        .free_rdata   (free_rdata),
        .audio_rdata  (audio_rdata),
        .video_rdata  (video_rdata)
    );

    // The free ring reads back its reset contents until an entry is written.
    pbpm_free_ram u_free_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (req.we[RING_FREE]),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re[RING_FREE]),
        .raddr (req.raddr),
        .rdata (free_rdata)
    );

    // The class rings are only read at entries that a put has written.
    pbpm_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (HANDLE_W)
    ) u_audio_ram (
        .clk   (clk),
        .we    (req.we[RING_AUDIO]),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re[RING_AUDIO]),
        .raddr (req.raddr),
        .rdata (audio_rdata)
    );

    pbpm_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (HANDLE_W)
    ) u_video_ram (
        .clk   (clk),
        .we    (req.we[RING_VIDEO]),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re[RING_VIDEO]),
        .raddr (req.raddr),
        .rdata (video_rdata)
    );

    // Output register: it is loaded when empty or when its transfer
    // completes in the same cycle.
    assign res_ready = !out_tvalid_reg || m_axis_tready;

    always_comb
    begin
        out_tvalid_next = out_tvalid_reg;
        out_tdata_next  = out_tdata_reg;
        out_tuser_next  = out_tuser_reg;
        if (res_ready)
        begin
            out_tvalid_next = res_valid;
            if (res_valid)
            begin
                out_tdata_next = {3'b000, res.video_level, res.audio_level,
                                  res.free_level, res.status, res.handle};
                out_tuser_next = res.valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tvalid_reg <= 1'b0;
        end
        else
        begin
            out_tvalid_reg <= out_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

    assign m_axis_tvalid = out_tvalid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

endmodule

/* test/pbpm_result_checker.sv */
module pbpm_result_checker
    import pbpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] handle, [7:6] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] action

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [5:0] out_handle, [7:6] status,
                                        // [14:8] free_level, [21:15] audio_level,
                                        // [28:22] video_level, [31:29] zero
    input  logic        m_axis_tuser,   // [0] out_valid

    output int          fail_count,
    output int          owed_count,
    output int          checked_count,
    output int          empty_count,
    output int          full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the three rings, indexed by ring_id_t.
    logic [HANDLE_W-1:0] ring_mem [NUM_RINGS][DEPTH];
    int                  ring_rd  [NUM_RINGS];
    int                  ring_wr  [NUM_RINGS];
    int                  ring_cnt [NUM_RINGS];

    result_t owed_results[$];
    int      errors;
    int      n_checked;
    int      n_empty;
    int      n_full;

    function automatic void pool_reset();
        for (int r = 0; r < NUM_RINGS; r++)
        begin
            ring_rd[r]  = 0;
            ring_wr[r]  = 0;
            ring_cnt[r] = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_mem[r][i] = (r == RING_FREE) ? HANDLE_W'(i) : '0;
            end
        end
        ring_cnt[RING_FREE] = DEPTH;
    endfunction

    function automatic bit ring_push(input int r, input logic [HANDLE_W-1:0] h);
        if (ring_cnt[r] >= DEPTH)
        begin
            return 1'b0;
        end
        ring_mem[r][ring_wr[r]] = h;
        ring_wr[r]  = (ring_wr[r] + 1) % DEPTH;
        ring_cnt[r] = ring_cnt[r] + 1;
        return 1'b1;
    endfunction

    function automatic bit ring_pop(input int r, output logic [HANDLE_W-1:0] h);
        h = '0;
        if (ring_cnt[r] == 0)
        begin
            return 1'b0;
        end
        h = ring_mem[r][ring_rd[r]];
        ring_rd[r]  = (ring_rd[r] + 1) % DEPTH;
        ring_cnt[r] = ring_cnt[r] - 1;
        return 1'b1;
    endfunction

    // Applies one request to the shadow rings and returns the result it must produce.
    function automatic result_t pool_predict(input action_t act,
                                             input logic [HANDLE_W-1:0] h);
        result_t             res;
        logic [HANDLE_W-1:0] moved;
        bit                  lost;
        res        = '0;
        res.status = ST_OK;
        lost       = 1'b0;
        case (act)
            ACT_FREE_RET:   if (!ring_push(RING_FREE, h))  res.status = ST_FULL;
            ACT_AUDIO_PUT:  if (!ring_push(RING_AUDIO, h)) res.status = ST_FULL;
            ACT_VIDEO_PUT:  if (!ring_push(RING_VIDEO, h)) res.status = ST_FULL;
            ACT_FREE_TAKE:  res.valid = ring_pop(RING_FREE, res.handle);
            ACT_AUDIO_TAKE: res.valid = ring_pop(RING_AUDIO, res.handle);
            ACT_VIDEO_TAKE: res.valid = ring_pop(RING_VIDEO, res.handle);
            ACT_FLUSH:
            begin
                // Audio drains first, then video; a handle that finds the free
                // ring full is lost, and both class rings restart at slot zero.
                foreach (ring_rd[r])
                begin
                    if (r != RING_FREE)
                    begin
                        while (ring_pop(r, moved))
                        begin
                            if (!ring_push(RING_FREE, moved))
                            begin
                                lost = 1'b1;
                            end
                        end
                        ring_rd[r] = 0;
                        ring_wr[r] = 0;
                    end
                end
                if (lost)
                begin
                    res.status = ST_FULL;
                end
            end
            default:
            begin
            end
        endcase
        if ((act == ACT_FREE_TAKE || act == ACT_AUDIO_TAKE || act == ACT_VIDEO_TAKE)
            && !res.valid)
        begin
            res.status = ST_EMPTY;
        end
        res.free_level  = LEVEL_W'(ring_cnt[RING_FREE]);
        res.audio_level = LEVEL_W'(ring_cnt[RING_AUDIO]);
        res.video_level = LEVEL_W'(ring_cnt[RING_VIDEO]);
        return res;
    endfunction

    function automatic void check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            pool_reset();
            owed_results.delete();
        end
        else
        begin
            // Retire the output first: it always belongs to an earlier request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.handle      = m_axis_tdata[5:0];
                got.status      = status_t'(m_axis_tdata[7:6]);
                got.free_level  = m_axis_tdata[14:8];
                got.audio_level = m_axis_tdata[21:15];
                got.video_level = m_axis_tdata[28:22];
                got.valid       = m_axis_tuser;
                if (owed_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result transfer with no request outstanding", $time);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("out_handle", want.handle, got.handle);
                    check_field("out_valid", want.valid, got.valid);
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("free_level", want.free_level, got.free_level);
                    check_field("audio_level", want.audio_level, got.audio_level);
                    check_field("video_level", want.video_level, got.video_level);
                    check_field("tdata pad", 0, m_axis_tdata[31:29]);
                    n_checked++;
                    if (want.status == ST_EMPTY)
                    begin
                        n_empty++;
                    end
                    if (want.status == ST_FULL)
                    begin
                        n_full++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                owed_results.push_back(pool_predict(action_t'(s_axis_tuser),
                                                    s_axis_tdata[HANDLE_W-1:0]));
            end
        end
        fail_count    <= errors;
        owed_count    <= owed_results.size();
        checked_count <= n_checked;
        empty_count   <= n_empty;
        full_count    <= n_full;
    end

endmodule

/* test/tb_packet_buffer_pool_manager_unit.sv */
// Top of the pool manager bench. It drives requests into the block, takes
// results out with random back pressure and leaves all prediction and
// comparison to the checker that sits beside the block.
module tb_packet_buffer_pool_manager_unit;
    import pbpm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQUEST_TARGET = 1300;
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int HOLD_AFTER     = 300;    // results taken before the hold-off
    localparam int SETTLE_CYCLES  = 20;
    localparam int CYCLE_LIMIT    = 1000000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = ACT_NOP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int owed_count;
    int checked_count;
    int empty_count;
    int full_count;

    int cycles        = 0;
    int requests_sent = 0;
    int flushes_sent  = 0;
    int results_taken = 0;

    // Idle shaping. A calm flag turns off the random gaps for a stretch so that
    // back-to-back transfers are exercised as well as sparse ones. hold_active
    // tells the sender that the receiver is in its long hold-off, so the sender
    // keeps offering at full rate and the block has to stall its input.
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit hold_active = 1'b0;
    bit hold_done   = 1'b0;

    always #5 clk = ~clk;

    packet_buffer_pool_manager_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pbpm_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .owed_count    (owed_count),
        .checked_count (checked_count),
        .empty_count   (empty_count),
        .full_count    (full_count)
    );

    // Offers one request and returns at the edge where it was accepted. tvalid
    // is only lowered when a gap is drawn, so a request that follows at once
    // never sees tvalid dropped and raised in the same time step.
    task automatic offer(input action_t act, input logic [HANDLE_W-1:0] h);
        int gap;
        gap = (tx_calm || hold_active) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, h};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (act != ACT_NOP)
        begin
            requests_sent++;
        end
        if (act == ACT_FLUSH)
        begin
            flushes_sent++;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            tx_calm = !tx_calm;
        end
    endtask

    // Stops offering until every outstanding result has been taken. The first
    // edge lets the checker record the transfer that was just accepted.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (owed_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [HANDLE_W-1:0] any_handle();
        return HANDLE_W'($urandom_range(0, (1 << HANDLE_W) - 1));
    endfunction

    // Request stimulus and the verdict.
    initial
    begin : stimulus
        int      pick;
        int      run_len;
        bit      paused;
        action_t act;
        action_t put_act;
        paused = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Right after reset the free ring is full and both class
        // rings are empty, so the first few requests hit the edge cases.
        offer(ACT_FREE_RET, 6'd63);     // return to a full free ring is dropped
        offer(ACT_AUDIO_TAKE, 6'd63);   // take from an empty audio ring
        offer(ACT_VIDEO_TAKE, 6'd0);    // take from an empty video ring
        offer(ACT_FLUSH, 6'd0);         // flush with nothing queued
        offer(ACT_NOP, 6'd21);          // action seven changes nothing
        offer(ACT_FREE_TAKE, 6'd0);     // handle 0 comes out first
        offer(ACT_FREE_TAKE, 6'd42);    // then handle 1; the handle field is ignored
        offer(ACT_AUDIO_PUT, 6'd0);
        offer(ACT_AUDIO_PUT, 6'd63);
        offer(ACT_VIDEO_PUT, 6'd1);
        offer(ACT_VIDEO_PUT, 6'd42);
        offer(ACT_AUDIO_TAKE, 6'd0);
        offer(ACT_VIDEO_TAKE, 6'd0);
        offer(ACT_FLUSH, 6'd0);         // fits: the free ring ends full again
        offer(ACT_AUDIO_PUT, 6'd21);    // duplicate handles are stored as they are
        offer(ACT_VIDEO_PUT, 6'd63);
        offer(ACT_FLUSH, 6'd0);         // no room left, so the moved handles are lost
        offer(ACT_FREE_TAKE, 6'd0);
        offer(ACT_FREE_RET, 6'd63);
        offer(ACT_FREE_RET, 6'd0);      // full again, dropped
        offer(ACT_NOP, 6'd63);

        // Random part. Runs of one action push the rings to full and to empty,
        // buffer life cycles model normal traffic, and the rest is flushes and
        // unconstrained noise.
        while (requests_sent < REQUEST_TARGET)
        begin
            if (!paused && requests_sent >= REQUEST_TARGET / 2)
            begin
                paused = 1'b1;
                wait_until_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                act     = action_t'($urandom_range(ACT_FREE_RET, ACT_VIDEO_TAKE));
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(1, 8);
                repeat (run_len) offer(act, any_handle());
            end
            else if (pick < 75)
            begin
                // Take a buffer, queue it on a class, maybe consume it, give it back.
                put_act = $urandom_range(0, 1) ? ACT_AUDIO_PUT : ACT_VIDEO_PUT;
                offer(ACT_FREE_TAKE, any_handle());
                offer(put_act, any_handle());
                if ($urandom_range(0, 2) != 0)
                begin
                    offer(action_t'(put_act + 3'd1), any_handle());
                end
                offer(ACT_FREE_RET, any_handle());
            end
            else if (pick < 85)
            begin
                offer(ACT_FLUSH, any_handle());
            end
            else
            begin
                offer(action_t'($urandom_range(ACT_FREE_RET, ACT_NOP)), any_handle());
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests including %0d flushes; %0d results checked,",
                 requests_sent, flushes_sent, checked_count);
        $display("with %0d empty takes and %0d dropped puts or lossy flushes",
                 empty_count, full_count);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side. Each result waits a random stall; once, after enough results,
    // tready is held low for a long stretch so the input side backs up.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && results_taken >= HOLD_AFTER)
            begin
                hold_done     = 1'b1;
                hold_active   = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active   = 1'b0;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_axis_tvalid);
            results_taken++;
            if ($urandom_range(0, 19) == 0)
            begin
                rx_calm = !rx_calm;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

endmodule

/* packet_buffer_pool_manager_unit.f */
rtl/core/pbpm_pkg.sv
rtl/core/pbpm_ram.sv
rtl/core/pbpm_free_ram.sv
rtl/core/pbpm_ctrl.sv
rtl/core/packet_buffer_pool_manager_unit.sv
test/pbpm_result_checker.sv
test/tb_packet_buffer_pool_manager_unit.sv
